[hw/rtl/icrp_pkg.sv]
// ----------------------------------------------------------------------------
// icrp_pkg
// Shared types, codes and constants of the isochronous channel ring placer.
// ----------------------------------------------------------------------------
package icrp_pkg;

	localparam int NUM_PORTS_DEF = 5;
	localparam int NUM_CHAN_REGS = 5;
	localparam int HDR_QUADS     = 4;

	localparam int PORT_W   = 3;
	localparam int CHAN_W   = 6;
	localparam int QUAD_W   = 16;
	localparam int LEN_W    = 13;
	localparam int DQ_W     = 12;
	localparam int CNT_W    = 32;
	localparam int STATUS_W = 2;

	localparam int CFG_AW     = 5;
	localparam int CFG_DW     = 32;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 128;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_PORT_ENABLE   = 3'd0;
	localparam logic [2:0] REG_BUFFER_QUADS  = 3'd1;
	localparam logic [2:0] REG_PORT0_CHANNEL = 3'd2;
	localparam logic [2:0] REG_PORT1_CHANNEL = 3'd3;
	localparam logic [2:0] REG_PORT2_CHANNEL = 3'd4;
	localparam logic [2:0] REG_PORT3_CHANNEL = 3'd5;
	localparam logic [2:0] REG_PORT4_CHANNEL = 3'd6;

	localparam logic [QUAD_W-1:0] BUFFER_QUADS_RST = 16'd4096;

	localparam logic OP_PACKET      = 1'b0;
	localparam logic OP_HEAD_UPDATE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;

	typedef struct packed {
		logic [NUM_CHAN_REGS-1:0]             enable;
		logic [NUM_CHAN_REGS-1:0]             clr;
		logic [QUAD_W-1:0]                    bufq;
		logic [NUM_CHAN_REGS-1:0][CHAN_W-1:0] chan;
	} cfg_t;

	typedef struct packed {
		logic [QUAD_W-1:0] head;
		logic [QUAD_W-1:0] tail;
		logic [CNT_W-1:0]  pkt_cnt;
		logic [CNT_W-1:0]  drop_cnt;
	} port_rec_t;

endpackage

[hw/rtl/iso_channel_ring_placer_unit.sv]
// ----------------------------------------------------------------------------
// iso_channel_ring_placer_unit
// Places isochronous packets into per-port ring buffers and reports offsets.
// ----------------------------------------------------------------------------
// A packet transaction is offered to ports 0 to NUM_PORTS-1 in turn, one port
// per cycle unless a result waits on m_axis_tready, and every enabled,
// uncorrupted port on the packet's channel yields one result, the final one
// flagged by tlast. Port state (head, tail, packet and drop counters) lives in
// a one-read one-write state memory with a registered read; each matching port
// is read in its scan cycle and updated as it leaves the execute stage. The
// input stays closed while a packet's ports or a head update are scanned.
// Entry valid bits stand in for the cleared state after reset or after a port
// enable rises, so no clearing pass runs.
module iso_channel_ring_placer_unit import icrp_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_AW-1:0]     paddr,
	input  logic [CFG_DW-1:0]     pwdata,
	output logic [CFG_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// packet_header, length_bytes, cycle_counter, target_port, new_head
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// port_index, header_offset, data_offset, trailer_offset, data_quads,
	// packet_number, drop_total, one zero pad bit
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [STATUS_W-1:0]   m_axis_tuser,
	output logic                  m_axis_tlast
);

	localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int NACT   = (NUM_PORTS < NUM_CHAN_REGS) ? NUM_PORTS : NUM_CHAN_REGS;
	localparam logic [PORT_W:0]   NP_EXT    = (PORT_W+1)'(NUM_PORTS);
	localparam logic [PIDX_W-1:0] LAST_PORT = PIDX_W'(NUM_PORTS - 1);

	cfg_t cfg;

	icrp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// item registers, held while the ports are scanned
	logic              busy_q;
	logic [PIDX_W-1:0] scan_q;
	logic              op_q;
	logic [CHAN_W-1:0] chan_q;
	logic [DQ_W-1:0]   xq_q;
	logic [PORT_W-1:0] tport_q;
	logic [QUAD_W-1:0] nhead_q;

	// execute stage
	logic              v_s1;
	logic              op_s1;
	logic              last_s1;
	logic              vld_s1;
	logic [PIDX_W-1:0] port_s1;
	port_rec_t         rec_s1;

	// per-port flops
	logic [NUM_PORTS-1:0] ent_vld_q;
	logic [NUM_PORTS-1:0] corrupt_q;
	logic [NUM_PORTS-1:0] port_clr;
	logic [NUM_PORTS-1:0] match;

	// output register
	logic                m_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [PORT_W-1:0]   pidx_q;
	logic [QUAD_W-1:0]   hoff_q;
	logic [QUAD_W-1:0]   doff_q;
	logic [QUAD_W-1:0]   toff_q;
	logic [DQ_W-1:0]     dq_q;
	logic [CNT_W-1:0]    pn_q;
	logic [CNT_W-1:0]    dt_q;
	logic                last_q;

	port_rec_t         mem [NUM_PORTS];
	logic              mem_re;
	logic              mem_we;
	logic [PIDX_W-1:0] rd_addr;
	port_rec_t         mem_wdata;

	logic s1_go;
	logic s0_adv;
	logic s_acc;
	logic later;
	logic tport_ok;
	logic issue;
	logic issue_last;

	for (genvar g = 0; g < NUM_PORTS; g++) begin : g_port
		if (g < NACT) begin : g_act
			assign port_clr[g] = cfg.clr[g];
			assign match[g] = cfg.enable[g] && !corrupt_q[g] && (cfg.chan[g] == chan_q);
		end else begin : g_none
			assign port_clr[g] = 1'b0;
			assign match[g]    = 1'b0;
		end
	end

	assign s1_go  = (op_s1 == OP_HEAD_UPDATE) || !m_valid_q || m_axis_tready;
	assign s0_adv = !v_s1 || s1_go;
	assign s_axis_tready = !busy_q && s0_adv;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign tport_ok = {1'b0, tport_q} < NP_EXT;

	// any matching port after the one being scanned
	always_comb begin
		later = 1'b0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (PIDX_W'(p) > scan_q) later = later | match[p];
		end
	end

	always_comb begin
		issue      = 1'b0;
		issue_last = 1'b0;
		rd_addr    = scan_q;
		if (busy_q && s0_adv) begin
			if (op_q == OP_HEAD_UPDATE) begin
				issue   = tport_ok;
				rd_addr = PIDX_W'(tport_q);
			end else begin
				issue      = match[scan_q];
				issue_last = !later;
			end
		end
	end
	assign mem_re = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			scan_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (s_acc) begin
				busy_q <= 1'b1;
				scan_q <= '0;
			end else if (busy_q && s0_adv) begin
				if (op_q == OP_HEAD_UPDATE || scan_q == LAST_PORT) begin
					busy_q <= 1'b0;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q    <= s_axis_tuser[0];
			chan_q  <= s_axis_tdata[13:8];
			xq_q    <= DQ_W'(({1'b0, s_axis_tdata[44:32]} + 14'd3) >> 2);
			tport_q <= s_axis_tdata[79:77];
			nhead_q <= s_axis_tdata[95:80];
		end
		if (issue) begin
			op_s1   <= op_q;
			port_s1 <= rd_addr;
			last_s1 <= issue_last;
			vld_s1  <= ent_vld_q[rd_addr];
		end
	end

	// placement arithmetic
	port_rec_t         rec;
	logic [QUAD_W:0]   bufq17;
	logic [QUAD_W:0]   head17;
	logic [QUAD_W:0]   tail17;
	logic [QUAD_W:0]   tail_need;
	logic [QUAD_W:0]   wrap_need;
	logic [QUAD_W:0]   doff17;
	logic [QUAD_W+1:0] toff18;
	logic [LEN_W-1:0]  need;
	logic              bad_head;
	logic              bad_slot;
	logic              at_tail;
	logic              wrap;
	logic              drop;
	logic              ex_corrupt;

	logic [STATUS_W-1:0] ex_status;
	logic [QUAD_W-1:0]   ex_hoff;
	logic [QUAD_W-1:0]   ex_doff;
	logic [QUAD_W-1:0]   ex_toff;
	logic [DQ_W-1:0]     ex_dq;
	logic [CNT_W-1:0]    ex_dt;

	always_comb begin
		rec       = vld_s1 ? rec_s1 : '0;
		bufq17    = {1'b0, cfg.bufq};
		head17    = {1'b0, rec.head};
		tail17    = {1'b0, rec.tail};
		need      = LEN_W'(xq_q) + LEN_W'(2 * HDR_QUADS);
		tail_need = tail17 + (QUAD_W+1)'(need);
		wrap_need = (QUAD_W+1)'(xq_q) + (QUAD_W+1)'(HDR_QUADS);
		bad_head  = head17 > bufq17;
		if (tail17 >= head17) begin
			at_tail = bufq17 >= tail_need;
			wrap    = !at_tail && (head17 >= wrap_need);
		end else begin
			at_tail = head17 >= tail_need;
			wrap    = 1'b0;
		end
		drop     = !at_tail && !wrap;
		doff17   = at_tail ? tail17 + (QUAD_W+1)'(HDR_QUADS) : '0;
		toff18   = {1'b0, doff17} + (QUAD_W+2)'(xq_q);
		bad_slot = (tail17 >= bufq17) || (toff18 >= {2'b00, cfg.bufq});
		ex_corrupt = bad_head || (!drop && bad_slot);

		ex_hoff = '0;
		ex_doff = '0;
		ex_toff = '0;
		ex_dq   = '0;
		ex_dt   = rec.drop_cnt;
		if (ex_corrupt) begin
			ex_status = ST_CORRUPT;
		end else if (drop) begin
			ex_status = ST_DROPPED;
			ex_dq     = xq_q;
			ex_dt     = rec.drop_cnt + 1'b1;
		end else begin
			ex_status = ST_PLACED;
			ex_hoff   = rec.tail;
			ex_doff   = doff17[QUAD_W-1:0];
			ex_toff   = toff18[QUAD_W-1:0];
			ex_dq     = xq_q;
		end

		mem_wdata = rec;
		if (op_s1 == OP_HEAD_UPDATE) begin
			mem_wdata.head = nhead_q;
		end else begin
			mem_wdata.pkt_cnt  = rec.pkt_cnt + 1'b1;
			mem_wdata.drop_cnt = ex_dt;
			if (!drop) mem_wdata.tail = ex_toff;
		end
	end

	assign mem_we = v_s1 && s1_go && ((op_s1 == OP_HEAD_UPDATE) || !ex_corrupt);

	always_ff @(posedge clk) begin
		if (mem_we) mem[port_s1] <= mem_wdata;
		if (mem_re) rec_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			corrupt_q <= '0;
		end else begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				if (port_clr[p]) begin
					ent_vld_q[p] <= 1'b0;
					corrupt_q[p] <= 1'b0;
				end else if (v_s1 && s1_go && port_s1 == PIDX_W'(p)) begin
					if (mem_we) ent_vld_q[p] <= 1'b1;
					if (op_s1 == OP_PACKET && ex_corrupt) corrupt_q[p] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (v_s1 && s1_go && op_s1 == OP_PACKET) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_go && op_s1 == OP_PACKET) begin
			status_q <= ex_status;
			pidx_q   <= PORT_W'(port_s1);
			hoff_q   <= ex_hoff;
			doff_q   <= ex_doff;
			toff_q   <= ex_toff;
			dq_q     <= ex_dq;
			pn_q     <= rec.pkt_cnt;
			dt_q     <= ex_dt;
			last_q   <= last_s1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {1'b0, dt_q, pn_q, dq_q, toff_q, doff_q, hoff_q, pidx_q};

endmodule

[hw/rtl/icrp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// icrp_cfg_regs
// APB register file: port enables, ring size and per-port channel numbers.
// ----------------------------------------------------------------------------
module icrp_cfg_regs import icrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output cfg_t              cfg
);

	logic [NUM_CHAN_REGS-1:0]             enable_q;
	logic [QUAD_W-1:0]                    bufq_q;
	logic [NUM_CHAN_REGS-1:0][CHAN_W-1:0] chan_q;
	logic [2:0]                           idx;
	logic                                 wr;

	assign idx = paddr[CFG_AW-1:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			bufq_q   <= BUFFER_QUADS_RST;
			chan_q   <= '0;
		end else if (wr) begin
			case (idx)
				REG_PORT_ENABLE:   enable_q  <= pwdata[NUM_CHAN_REGS-1:0];
				REG_BUFFER_QUADS:  bufq_q    <= pwdata[QUAD_W-1:0];
				REG_PORT0_CHANNEL: chan_q[0] <= pwdata[CHAN_W-1:0];
				REG_PORT1_CHANNEL: chan_q[1] <= pwdata[CHAN_W-1:0];
				REG_PORT2_CHANNEL: chan_q[2] <= pwdata[CHAN_W-1:0];
				REG_PORT3_CHANNEL: chan_q[3] <= pwdata[CHAN_W-1:0];
				REG_PORT4_CHANNEL: chan_q[4] <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// ports whose enable rises are cleared in the same transaction
	always_comb begin
		cfg.enable = enable_q;
		cfg.bufq   = bufq_q;
		cfg.chan   = chan_q;
		cfg.clr    = '0;
		if (wr && idx == REG_PORT_ENABLE) begin
			cfg.clr = pwdata[NUM_CHAN_REGS-1:0] & ~enable_q;
		end
	end

	always_comb begin
		case (idx)
			REG_PORT_ENABLE:   prdata = CFG_DW'(enable_q);
			REG_BUFFER_QUADS:  prdata = CFG_DW'(bufq_q);
			REG_PORT0_CHANNEL: prdata = CFG_DW'(chan_q[0]);
			REG_PORT1_CHANNEL: prdata = CFG_DW'(chan_q[1]);
			REG_PORT2_CHANNEL: prdata = CFG_DW'(chan_q[2]);
			REG_PORT3_CHANNEL: prdata = CFG_DW'(chan_q[3]);
			REG_PORT4_CHANNEL: prdata = CFG_DW'(chan_q[4]);
			default:           prdata = '0;
		endcase
	end

endmodule

[hw/rtl/icrp_checker.sv]
// ----------------------------------------------------------------------------
// icrp_checker
// Port-level assertions for the ring placer, bound to the top level.
// ----------------------------------------------------------------------------
module icrp_checker import icrp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [STATUS_W-1:0]   m_axis_tuser,
	input logic                  m_axis_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// the port scan keeps the input closed right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted during port scan");

	a_corrupt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_CORRUPT |->
		m_axis_tdata[62:3] == '0)
		else $error("corrupted result carries offsets");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_DROPPED |->
		m_axis_tdata[50:3] == '0)
		else $error("dropped result carries offsets");

	// trailer follows the data, data follows the header or wraps to zero
	a_placed_layout: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_PLACED |->
		(m_axis_tdata[50:35] == 16'(m_axis_tdata[34:19] + 16'(m_axis_tdata[62:51])))
		&& ((m_axis_tdata[34:19] == 16'd0)
		|| (m_axis_tdata[34:19] == 16'(m_axis_tdata[18:3] + 16'(HDR_QUADS)))))
		else $error("placed result layout broken");

endmodule

bind iso_channel_ring_placer_unit icrp_checker u_icrp_checker (.*);

[test/tb_iso_channel_ring_placer_unit.sv]
// ----------------------------------------------------------------------------
// tb_iso_channel_ring_placer_unit
// Self-checking bench for the isochronous channel ring placer. A scoreboard
// class tracks per-port ring state and predicts the placement, drop and
// corruption results of every accepted packet. A short directed sequence
// covers wrap, drop, corruption and ignored head updates. Randomized phases
// then follow, each with its own register settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_iso_channel_ring_placer_unit import icrp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WATCHDOG_LIMIT  = 4000;
	localparam int          SETTLE_CYCLES   = NUM_PORTS_DEF + 4;
	localparam int          NUM_PHASES      = 12;
	localparam int          ITEMS_PER_PHASE = 30;
	localparam logic [2:0]  REG_SPARE       = 3'd7;

	typedef struct {
		logic [PORT_W-1:0]   port;
		logic [STATUS_W-1:0] status;
		logic [QUAD_W-1:0]   hdr_off;
		logic [QUAD_W-1:0]   data_off;
		logic [QUAD_W-1:0]   trl_off;
		logic [DQ_W-1:0]     quads;
		logic [CNT_W-1:0]    pkt_num;
		logic [CNT_W-1:0]    drops;
		logic                last;
	} placement_t;

	class ring_placement_board;
		logic [NUM_CHAN_REGS-1:0] enable_bits;
		logic [QUAD_W-1:0]        ring_quads;
		logic [CHAN_W-1:0]        chan_of[NUM_PORTS_DEF];
		logic [QUAD_W-1:0]        tail_q[NUM_PORTS_DEF];
		logic [QUAD_W-1:0]        head_q[NUM_PORTS_DEF];
		bit                       corrupt[NUM_PORTS_DEF];
		logic [CNT_W-1:0]         pkt_count[NUM_PORTS_DEF];
		logic [CNT_W-1:0]         drop_count[NUM_PORTS_DEF];
		placement_t               expected_q[$];
		int unsigned              fails;

		function new();
			enable_bits = '0;
			ring_quads  = BUFFER_QUADS_RST;
			fails       = 0;
			for (int p = 0; p < NUM_PORTS_DEF; p++) begin
				chan_of[p] = '0;
				clear_port(p);
			end
		endfunction

		function void clear_port(int p);
			tail_q[p]     = '0;
			head_q[p]     = '0;
			corrupt[p]    = 1'b0;
			pkt_count[p]  = '0;
			drop_count[p] = '0;
		endfunction

		function void apply_reg(logic [2:0] idx, logic [CFG_DW-1:0] v);
			logic [NUM_CHAN_REGS-1:0] nv;
			nv = v[NUM_CHAN_REGS-1:0];
			case (idx)
				REG_PORT_ENABLE: begin
					// a rising enable bit clears that port
					for (int p = 0; p < NUM_PORTS_DEF; p++)
						if (nv[p] && !enable_bits[p])
							clear_port(p);
					enable_bits = nv;
				end
				REG_BUFFER_QUADS: ring_quads = v[QUAD_W-1:0];
				REG_PORT0_CHANNEL, REG_PORT1_CHANNEL, REG_PORT2_CHANNEL,
				REG_PORT3_CHANNEL, REG_PORT4_CHANNEL:
					chan_of[idx - REG_PORT0_CHANNEL] = v[CHAN_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(logic op, logic [IN_DATA_W-1:0] d);
			logic [CHAN_W-1:0] chan;
			int         xq, bufq, hd, tl, need, hoff, doff, toff;
			bit         drop, have_prev;
			placement_t r, prev;
			if (op == OP_HEAD_UPDATE) begin
				if (d[79:77] < PORT_W'(NUM_PORTS_DEF))
					head_q[d[79:77]] = d[95:80];
				return;
			end
			chan      = d[13:8];
			xq        = (int'(d[44:32]) + 3) / 4;
			bufq      = int'(ring_quads);
			have_prev = 1'b0;
			for (int p = 0; p < NUM_PORTS_DEF; p++) begin
				if (!enable_bits[p] || corrupt[p] || chan_of[p] != chan)
					continue;
				hd         = int'(head_q[p]);
				tl         = int'(tail_q[p]);
				r.port     = PORT_W'(p);
				r.last     = 1'b0;
				r.hdr_off  = '0;
				r.data_off = '0;
				r.trl_off  = '0;
				r.quads    = '0;
				r.status   = ST_CORRUPT;
				r.pkt_num  = pkt_count[p];
				r.drops    = drop_count[p];
				if (hd > bufq) begin
					corrupt[p] = 1'b1;
				end else begin
					need = 2 * HDR_QUADS + xq;
					drop = 1'b0;
					hoff = tl;
					doff = tl + HDR_QUADS;
					if (tl >= hd) begin
						if (bufq - tl < need) begin
							// header stays at the tail, data wraps to the front
							if (hd >= need - HDR_QUADS)
								doff = 0;
							else
								drop = 1'b1;
						end
					end else if (hd - tl < need) begin
						drop = 1'b1;
					end
					toff = doff + xq;
					if (drop) begin
						drop_count[p]++;
						pkt_count[p]++;
						r.status = ST_DROPPED;
						r.quads  = DQ_W'(xq);
						r.drops  = drop_count[p];
					end else if (hoff >= bufq || toff >= bufq) begin
						corrupt[p] = 1'b1;
					end else begin
						r.status   = ST_PLACED;
						r.hdr_off  = QUAD_W'(hoff);
						r.data_off = QUAD_W'(doff);
						r.trl_off  = QUAD_W'(toff);
						r.quads    = DQ_W'(xq);
						tail_q[p]  = QUAD_W'(toff);
						pkt_count[p]++;
					end
				end
				if (have_prev)
					expected_q.push_back(prev);
				prev      = r;
				have_prev = 1'b1;
			end
			if (have_prev) begin
				prev.last = 1'b1;
				expected_q.push_back(prev);
			end
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d, logic [STATUS_W-1:0] st,
			logic lst);
			placement_t e;
			if (expected_q.size() == 0) begin
				$error("result transaction with no expected placement: port %0d status %0d",
					d[2:0], st);
				fails++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("port_index", 64'(e.port), 64'(d[2:0]));
			compare_field("status", 64'(e.status), 64'(st));
			compare_field("header_offset", 64'(e.hdr_off), 64'(d[18:3]));
			compare_field("data_offset", 64'(e.data_off), 64'(d[34:19]));
			compare_field("trailer_offset", 64'(e.trl_off), 64'(d[50:35]));
			compare_field("data_quads", 64'(e.quads), 64'(d[62:51]));
			compare_field("packet_number", 64'(e.pkt_num), 64'(d[94:63]));
			compare_field("drop_total", 64'(e.drops), 64'(d[126:95]));
			compare_field("last", 64'(e.last), 64'(lst));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_AW-1:0]     paddr;
	logic [CFG_DW-1:0]     pwdata;
	logic [CFG_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	logic                  m_axis_tlast;

	ring_placement_board board;
	int unsigned         sender_idle_pct;
	int unsigned         recv_stall_pct;
	int unsigned         quiet_cycles = 0;

	iso_channel_ring_placer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			board.note_item(s_axis_tuser[0], s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_item(logic [31:0] header,
		logic [LEN_W-1:0] len, logic [31:0] cycle, logic [PORT_W-1:0] port,
		logic [QUAD_W-1:0] head);
		return {head, port, cycle, len, header};
	endfunction

	function automatic logic [IN_DATA_W-1:0] packet_on(logic [CHAN_W-1:0] chan,
		logic [LEN_W-1:0] len);
		logic [31:0] header;
		header       = $urandom;
		header[13:8] = chan;
		return pack_item(header, len, $urandom, PORT_W'($urandom), QUAD_W'($urandom));
	endfunction

	function automatic logic [IN_DATA_W-1:0] head_move(logic [PORT_W-1:0] port,
		logic [QUAD_W-1:0] head);
		return pack_item($urandom, LEN_W'($urandom), $urandom, port, head);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.apply_reg(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(logic op, logic [IN_DATA_W-1:0] d);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tuser  <= op;
		s_axis_tdata  <= d;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// hold off the sender until every expected result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		write_reg(REG_PORT_ENABLE, 32'd31);
		write_reg(REG_BUFFER_QUADS, 32'd4096);
		write_reg(REG_PORT0_CHANNEL, 32'd5);
		write_reg(REG_PORT1_CHANNEL, 32'd5);
		write_reg(REG_PORT2_CHANNEL, 32'd63);
		write_reg(REG_PORT3_CHANNEL, 32'd0);
		write_reg(REG_PORT4_CHANNEL, 32'd5);
		write_reg(REG_SPARE, 32'hffff_ffff);
		send_item(OP_PACKET, packet_on(6'd5, 13'd0));
		send_item(OP_PACKET, pack_item('1, 13'd8191, '1, '1, '1));
		send_item(OP_PACKET, pack_item('0, 13'd1, '0, '0, '0));
		send_item(OP_PACKET, packet_on(6'd17, 13'd100));
		// head updates past the last port are ignored
		send_item(OP_HEAD_UPDATE, head_move(3'd5, 16'hffff));
		send_item(OP_HEAD_UPDATE, head_move(3'd6, 16'hffff));
		send_item(OP_HEAD_UPDATE, head_move(3'd7, 16'hffff));
		// head beyond the ring corrupts port 1
		send_item(OP_HEAD_UPDATE, head_move(3'd1, 16'hffff));
		send_item(OP_PACKET, packet_on(6'd5, 13'd40));
		send_item(OP_PACKET, packet_on(6'd5, 13'd13));
		send_item(OP_PACKET, packet_on(6'd63, 13'd8191));
		// head far enough forward lets the data wrap to offset 0
		send_item(OP_HEAD_UPDATE, head_move(3'd2, 16'd2052));
		send_item(OP_PACKET, packet_on(6'd63, 13'd8191));
		send_item(OP_PACKET, packet_on(6'd63, 13'd0));
		send_item(OP_HEAD_UPDATE, head_move(3'd2, 16'd4000));
		send_item(OP_PACKET, packet_on(6'd63, 13'd16));
		drain_results();
		// shrink the ring under a port whose tail is now out of range
		write_reg(REG_PORT_ENABLE, 32'd15);
		write_reg(REG_BUFFER_QUADS, 32'd100);
		send_item(OP_HEAD_UPDATE, head_move(3'd4, 16'd7));
		send_item(OP_PACKET, packet_on(6'd5, 13'd0));
		send_item(OP_HEAD_UPDATE, head_move(3'd2, 16'd50));
		send_item(OP_PACKET, packet_on(6'd63, 13'd0));
		send_item(OP_PACKET, packet_on(6'd0, 13'd8191));
		drain_results();
	endtask

	task automatic configure_phase(int ph);
		int unsigned pick;
		logic [QUAD_W-1:0] ring;
		case (ph % 4)
			0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
			default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
		endcase
		pick = $urandom_range(0, 99);
		if (ph == 0)
			ring = 16'd1;
		else if (ph == 1)
			ring = 16'hffff;
		else if (pick < 60)
			ring = QUAD_W'($urandom_range(24, 300));
		else if (pick < 80)
			ring = QUAD_W'($urandom_range(1, 4096));
		else
			ring = QUAD_W'($urandom_range(1, 65535));
		if (ph < 2 || $urandom_range(0, 1) == 0)
			write_reg(REG_PORT_ENABLE, 32'd0);
		write_reg(REG_PORT_ENABLE, (ph < 2) ? 32'd31 : 32'($urandom_range(1, 31)));
		write_reg(REG_BUFFER_QUADS, 32'(ring));
		for (int p = 0; p < NUM_CHAN_REGS; p++)
			write_reg(REG_PORT0_CHANNEL + 3'(p),
				($urandom_range(0, 9) == 0) ? 32'd63 : 32'($urandom_range(0, 3)));
	endtask

	task automatic run_random_item();
		int unsigned       pick;
		logic [CHAN_W-1:0] chan;
		logic [LEN_W-1:0]  len;
		logic [PORT_W-1:0] port;
		logic [QUAD_W-1:0] head;
		if ($urandom_range(0, 99) < 75) begin
			pick = $urandom_range(0, 99);
			chan = (pick < 85) ? CHAN_W'($urandom_range(0, 3)) :
				(pick < 90) ? 6'd63 : CHAN_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				len = LEN_W'($urandom_range(0, 127));
			else if (pick < 80)
				len = LEN_W'($urandom_range(0, 1023));
			else if (pick < 95)
				len = LEN_W'($urandom_range(0, 8191));
			else
				len = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
			send_item(OP_PACKET, packet_on(chan, len));
		end else begin
			port = ($urandom_range(0, 9) == 0) ? PORT_W'($urandom_range(5, 7)) :
				PORT_W'($urandom_range(0, 4));
			pick = $urandom_range(0, 99);
			// mostly a consumer catching up fully or partly with the producer
			if (port >= PORT_W'(NUM_PORTS_DEF) || pick >= 95)
				head = QUAD_W'($urandom);
			else if (pick < 60)
				head = board.tail_q[port];
			else if (pick < 80)
				head = QUAD_W'($urandom_range(0, board.tail_q[port]));
			else
				head = QUAD_W'($urandom_range(0, board.ring_quads));
			send_item(OP_HEAD_UPDATE, head_move(port, head));
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = '0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		board           = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure_phase(ph);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 3)
					drain_results();
				run_random_item();
			end
			drain_results();
		end
		if (board.fails == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
